[src/bsrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrm_pkg: shared constants for the shifted bitmap word server
// Field widths, opcodes, configuration register indexes and sweep sizes.
// ----------------------------------------------------------------------------
package bsrm_pkg;

  // Item fields
  localparam int OPCODE_W   = 1;
  localparam int IDX_W      = 16;
  localparam int WORD_BITS  = 32;
  localparam int OFF_W      = 5;               // log2 of WORD_BITS
  localparam int CNT_W      = 6;               // 0..WORD_BITS

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 1'b1;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_X   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SHIFT_Y   = 2'd3;

  localparam int DIM_W   = 13;                 // row width, row count
  localparam int SHIFT_W = 14;                 // signed displacements
  localparam logic [DIM_W-1:0] ROW_WIDTH_RST = 13'd64;
  localparam logic [DIM_W-1:0] ROW_COUNT_RST = 13'd64;

  // Pixel arithmetic: pixel positions of a 16-bit word index span 21 bits;
  // displacements and totals stay well inside 32 signed bits.
  localparam int P0_W    = IDX_W + OFF_W;
  localparam int PIX_W   = 32;
  localparam int RECIP_W = P0_W + 1;           // floor(2^P0_W / width)
  localparam int REM_W   = DIM_W + 1;          // remainder before correction

  // Setup sweep after reset or a register write
  localparam int SETTLE_LEN = 64;              // also the row pattern length
  localparam int SETTLE_CW  = 6;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int PEND_W     = 4;               // counts 0..FIFO_DEPTH

endpackage

[src/bsrm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrm channels: request and response handshake bundles
// Each carries valid, ready and the item payload.
// ----------------------------------------------------------------------------
interface bsrm_req_if;
  logic                           valid;
  logic                           ready;
  logic [bsrm_pkg::OPCODE_W-1:0]  opcode;
  logic [bsrm_pkg::IDX_W-1:0]     word_index;
  logic [bsrm_pkg::WORD_BITS-1:0] word_value;

  modport source (output valid, opcode, word_index, word_value, input ready);
  modport sink   (input valid, opcode, word_index, word_value, output ready);
endinterface

interface bsrm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bsrm_pkg::IDX_W-1:0]     result_index;
  logic [bsrm_pkg::WORD_BITS-1:0] shifted_word;
  logic [bsrm_pkg::CNT_W-1:0]     set_bit_count;

  modport source (output valid, result_index, shifted_word, set_bit_count, input ready);
  modport sink   (input valid, result_index, shifted_word, set_bit_count, output ready);
endinterface

[src/bitmap_shift_row_masked_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_shift_row_masked_top: shifted one-bit-per-pixel bitmap word server
// Stores source words in a dual-read memory and returns destination words of
// the bitmap moved by (shift_x, shift_y), with edge fill and row column mask.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while req.ready is high, writes and reads mixed freely.
// A read's result reaches rsp through the memory read, funnel/modulo, mask,
//   popcount and result queue registers.
// An eight-entry result queue lets input flow on while rsp stalls.
// Reset and every register write start a setup sweep (reciprocal of the row
//   width, short-row column pattern); req.ready stays low during it.
// The source memory is not cleared: read only words that were written.
// ----------------------------------------------------------------------------
module bitmap_shift_row_masked_top #(
  parameter int MAX_WORDS = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bsrm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bsrm_pkg::CFG_DATA_W-1:0] cfg_data,
  bsrm_req_if.sink                        req,
  bsrm_rsp_if.source                      rsp
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam longint unsigned PIX_CAP = longint'(MAX_WORDS) * bsrm_pkg::WORD_BITS;

  typedef struct packed {
    logic [bsrm_pkg::IDX_W-1:0]     idx;
    logic [bsrm_pkg::WORD_BITS-1:0] word;
    logic [bsrm_pkg::CNT_W-1:0]     cnt;
  } rsp_entry_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        [bsrm_pkg::DIM_W-1:0]   row_width;
  logic        [bsrm_pkg::DIM_W-1:0]   row_count;
  logic signed [bsrm_pkg::SHIFT_W-1:0] shift_x;
  logic signed [bsrm_pkg::SHIFT_W-1:0] shift_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= bsrm_pkg::ROW_WIDTH_RST;
      row_count <= bsrm_pkg::ROW_COUNT_RST;
      shift_x   <= '0;
      shift_y   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bsrm_pkg::REG_ROW_WIDTH: row_width <= cfg_data[bsrm_pkg::DIM_W-1:0];
        bsrm_pkg::REG_ROW_COUNT: row_count <= cfg_data[bsrm_pkg::DIM_W-1:0];
        bsrm_pkg::REG_SHIFT_X:   shift_x   <= $signed(cfg_data);
        bsrm_pkg::REG_SHIFT_Y:   shift_y   <= $signed(cfg_data);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Derived geometry, re-registered every cycle; stable once the sweep ends
  // --------------------------------------------------------------------------
  logic        [2*bsrm_pkg::DIM_W-1:0]             area;
  logic signed [bsrm_pkg::SHIFT_W+bsrm_pkg::DIM_W:0] dy_w;
  logic signed [bsrm_pkg::PIX_W-1:0]               pix_total_next, disp_next;
  logic        [bsrm_pkg::SHIFT_W-1:0]             dx_mag;
  logic                                            mask_en_next, w_small_next;
  logic        [bsrm_pkg::DIM_W-1:0]               mask_lo_next, mask_hi_next;

  logic signed [bsrm_pkg::PIX_W-1:0] pix_total, disp;
  logic                              mask_en, w_small;
  logic        [bsrm_pkg::DIM_W-1:0] mask_lo, mask_hi;

  assign area = row_width * row_count;
  // Clamp the pixel count to what the memory holds.
  assign pix_total_next = (64'(area) > PIX_CAP) ? bsrm_pkg::PIX_W'(PIX_CAP)
                                                 : bsrm_pkg::PIX_W'(area);
  assign dy_w      = shift_y * $signed({1'b0, row_width});
  assign disp_next = bsrm_pkg::PIX_W'(dy_w) + bsrm_pkg::PIX_W'(shift_x);

  // Vacated columns: [0, dx) for a right shift, [w+dx, w) for a left shift,
  // only while 0 < |dx| <= w.
  assign dx_mag       = shift_x[bsrm_pkg::SHIFT_W-1] ? (~shift_x + 1'b1) : shift_x;
  assign mask_en_next = (shift_x != '0) && (dx_mag <= {1'b0, row_width});
  assign mask_lo_next = shift_x[bsrm_pkg::SHIFT_W-1]
                        ? bsrm_pkg::DIM_W'(row_width - dx_mag[bsrm_pkg::DIM_W-1:0]) : '0;
  assign mask_hi_next = shift_x[bsrm_pkg::SHIFT_W-1]
                        ? row_width : dx_mag[bsrm_pkg::DIM_W-1:0];
  assign w_small_next = row_width < bsrm_pkg::DIM_W'(bsrm_pkg::WORD_BITS);

  always_ff @(posedge clk) begin
    pix_total <= pix_total_next;
    disp      <= disp_next;
    mask_en   <= mask_en_next;
    mask_lo   <= mask_lo_next;
    mask_hi   <= mask_hi_next;
    w_small   <= w_small_next;
  end

  // --------------------------------------------------------------------------
  // Setup sweep: restoring divide for floor(2^21 / w) at the start of the
  // sweep, and one row-pattern bit per cycle for rows narrower than a word.
  // --------------------------------------------------------------------------
  logic                                 busy;
  logic [bsrm_pkg::SETTLE_CW-1:0]       settle_cnt;
  logic [bsrm_pkg::DIM_W-1:0]           div_rem, div_step_rem;
  logic [bsrm_pkg::REM_W-1:0]           div_shift;
  logic                                 div_step_bit;
  logic [bsrm_pkg::RECIP_W-1:0]         recip;
  logic [bsrm_pkg::SETTLE_LEN-1:0]      pat;
  logic [bsrm_pkg::DIM_W-1:0]           pat_col, pat_col_inc;
  logic                                 pat_bit;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      busy       <= 1'b1;
      settle_cnt <= '0;
    end else if (busy) begin
      settle_cnt <= settle_cnt + 1'b1;
      if (settle_cnt == bsrm_pkg::SETTLE_CW'(bsrm_pkg::SETTLE_LEN - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The dividend is a single one in its top bit: feed 1 first, then zeros.
  assign div_shift    = {div_rem, (settle_cnt == '0)};
  assign div_step_bit = div_shift >= {1'b0, row_width};
  assign div_step_rem = div_step_bit ? bsrm_pkg::DIM_W'(div_shift - {1'b0, row_width})
                                     : div_shift[bsrm_pkg::DIM_W-1:0];

  assign pat_bit     = mask_en_next && (pat_col >= mask_lo_next) && (pat_col < mask_hi_next);
  assign pat_col_inc = (bsrm_pkg::DIM_W'(pat_col + 1'b1) == row_width)
                       ? '0 : bsrm_pkg::DIM_W'(pat_col + 1'b1);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      div_rem <= '0;
      recip   <= '0;
      pat_col <= '0;
    end else if (busy) begin
      if (settle_cnt < bsrm_pkg::SETTLE_CW'(bsrm_pkg::RECIP_W)) begin
        div_rem <= div_step_rem;
        recip   <= {recip[bsrm_pkg::RECIP_W-2:0], div_step_bit};
      end
      pat[settle_cnt] <= pat_bit;
      pat_col         <= pat_col_inc;
    end
  end

  // --------------------------------------------------------------------------
  // Input handshake and in-flight accounting
  // --------------------------------------------------------------------------
  logic                        in_take, rd_take, wr_en, pop;
  logic [bsrm_pkg::PEND_W-1:0] pending;

  // Admit a read only if the result queue is sure to have room for it.
  assign req.ready = !busy && (pending < bsrm_pkg::PEND_W'(bsrm_pkg::FIFO_DEPTH));
  assign in_take   = req.valid && req.ready;
  assign rd_take   = in_take && (req.opcode == bsrm_pkg::OP_READ);
  assign wr_en     = in_take && (req.opcode == bsrm_pkg::OP_WRITE)
                     && (32'(req.word_index) < 32'(MAX_WORDS));
  assign pop       = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + bsrm_pkg::PEND_W'(rd_take) - bsrm_pkg::PEND_W'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: source start position, memory addresses, reciprocal multiply
  // --------------------------------------------------------------------------
  logic                                      a_v;
  logic        [bsrm_pkg::IDX_W-1:0]         a_idx;
  logic signed [bsrm_pkg::PIX_W-1:0]         a_s0, s0_in, a_word;
  logic        [bsrm_pkg::P0_W-1:0]          a_p0;
  logic        [bsrm_pkg::P0_W+bsrm_pkg::RECIP_W-1:0] a_prod;
  logic        [AW-1:0]                      rd_addr_lo, rd_addr_hi;

  assign s0_in = bsrm_pkg::PIX_W'({req.word_index, bsrm_pkg::OFF_W'(0)}) - disp;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= rd_take;
    end
    a_idx <= req.word_index;
    a_s0  <= s0_in;
  end

  assign a_p0       = {a_idx, bsrm_pkg::OFF_W'(0)};
  assign a_word     = a_s0 >>> bsrm_pkg::OFF_W;
  assign rd_addr_lo = AW'(a_word);
  assign rd_addr_hi = rd_addr_lo + 1'b1;
  assign a_prod     = a_p0 * recip;

  // Source memory: one write port, two registered read ports.
  logic [bsrm_pkg::WORD_BITS-1:0] mem [MAX_WORDS];
  logic [bsrm_pkg::WORD_BITS-1:0] rd_lo, rd_hi;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(req.word_index)] <= req.word_value;
    end
    rd_lo <= mem[rd_addr_lo];
    rd_hi <= mem[rd_addr_hi];
  end

  // --------------------------------------------------------------------------
  // Stage B: funnel the two source words, range-check every bit, remainder
  // --------------------------------------------------------------------------
  logic                               b_v;
  logic        [bsrm_pkg::IDX_W-1:0]  b_idx;
  logic        [bsrm_pkg::P0_W-1:0]   b_p0, b_qest;
  logic        [bsrm_pkg::OFF_W-1:0]  b_off;
  logic signed [bsrm_pkg::PIX_W-1:0]  b_lim_p, b_lo_s, b_hi_s;
  logic        [bsrm_pkg::WORD_BITS-1:0] b_src, b_keep;
  logic        [2*bsrm_pkg::WORD_BITS-1:0] b_pair;
  logic        [bsrm_pkg::P0_W+bsrm_pkg::DIM_W-1:0] b_mul;
  logic        [bsrm_pkg::REM_W-1:0]  b_rem_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= a_v;
    end
    b_idx   <= a_idx;
    b_p0    <= a_p0;
    b_qest  <= a_prod[2*bsrm_pkg::P0_W-1:bsrm_pkg::P0_W];
    b_off   <= a_s0[bsrm_pkg::OFF_W-1:0];
    // bit k survives when p0+k < n and 0 <= s0+k < n
    b_lim_p <= pix_total - bsrm_pkg::PIX_W'(a_p0);
    b_lo_s  <= -a_s0;
    b_hi_s  <= pix_total - a_s0;
  end

  assign b_pair = {rd_hi, rd_lo} >> b_off;
  assign b_src  = b_pair[bsrm_pkg::WORD_BITS-1:0];

  always_comb begin
    logic signed [bsrm_pkg::PIX_W-1:0] kk;
    for (int k = 0; k < bsrm_pkg::WORD_BITS; k++) begin
      kk        = bsrm_pkg::PIX_W'(k);
      b_keep[k] = (kk < b_lim_p) && (kk >= b_lo_s) && (kk < b_hi_s);
    end
  end

  // Quotient estimate is exact or one short: remainder lands in [0, 2w).
  assign b_mul     = b_qest * row_width;
  assign b_rem_raw = bsrm_pkg::REM_W'(b_p0) - b_mul[bsrm_pkg::REM_W-1:0];

  // --------------------------------------------------------------------------
  // Stage C: column of the first bit, vacated-column mask, final word
  // --------------------------------------------------------------------------
  logic                                  c_v;
  logic [bsrm_pkg::IDX_W-1:0]            c_idx;
  logic [bsrm_pkg::WORD_BITS-1:0]        c_src, c_keep, c_mask, mask_big, mask_small;
  logic [bsrm_pkg::REM_W-1:0]            c_rem_raw;
  logic [bsrm_pkg::DIM_W-1:0]            c_col0;
  logic [bsrm_pkg::SETTLE_LEN-1:0]       pat_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= b_v;
    end
    c_idx     <= b_idx;
    c_src     <= b_src;
    c_keep    <= b_keep;
    c_rem_raw <= b_rem_raw;
  end

  assign c_col0 = (c_rem_raw >= {1'b0, row_width})
                  ? bsrm_pkg::DIM_W'(c_rem_raw - {1'b0, row_width})
                  : c_rem_raw[bsrm_pkg::DIM_W-1:0];

  // Rows of a word or wider: at most one wrap across the 32 bits.
  always_comb begin
    logic [bsrm_pkg::REM_W-1:0] t;
    logic [bsrm_pkg::REM_W-1:0] col;
    for (int k = 0; k < bsrm_pkg::WORD_BITS; k++) begin
      t           = {1'b0, c_col0} + bsrm_pkg::REM_W'(k);
      col         = (t >= {1'b0, row_width}) ? bsrm_pkg::REM_W'(t - {1'b0, row_width}) : t;
      mask_big[k] = mask_en && (col >= {1'b0, mask_lo}) && (col < {1'b0, mask_hi});
    end
  end

  // Short rows: pick 32 bits of the swept pattern starting at the column.
  assign pat_sh     = pat >> c_col0[bsrm_pkg::OFF_W-1:0];
  assign mask_small = pat_sh[bsrm_pkg::WORD_BITS-1:0];
  assign c_mask     = w_small ? mask_small : mask_big;

  // --------------------------------------------------------------------------
  // Stage D: popcount, then into the result queue
  // --------------------------------------------------------------------------
  logic                           d_v;
  logic [bsrm_pkg::IDX_W-1:0]     d_idx;
  logic [bsrm_pkg::WORD_BITS-1:0] d_word;
  logic [bsrm_pkg::CNT_W-1:0]     d_cnt;
  logic [3:0]                     byte_cnt [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else begin
      d_v <= c_v;
    end
    d_idx  <= c_idx;
    d_word <= c_src & c_keep & ~c_mask;
  end

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(d_word[8*b+i]);
      end
    end
    d_cnt = bsrm_pkg::CNT_W'(byte_cnt[0]) + bsrm_pkg::CNT_W'(byte_cnt[1])
          + bsrm_pkg::CNT_W'(byte_cnt[2]) + bsrm_pkg::CNT_W'(byte_cnt[3]);
  end

  // Result queue: the pending limit keeps it from overflowing.
  rsp_entry_t                   fifo [bsrm_pkg::FIFO_DEPTH];
  logic [bsrm_pkg::FIFO_AW:0]   wptr, rptr, fifo_cnt;
  rsp_entry_t                   head;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (d_v) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_v) begin
      fifo[wptr[bsrm_pkg::FIFO_AW-1:0]] <= '{idx: d_idx, word: d_word, cnt: d_cnt};
    end
  end

  assign fifo_cnt          = wptr - rptr;
  assign head              = fifo[rptr[bsrm_pkg::FIFO_AW-1:0]];
  assign rsp.valid         = (wptr != rptr);
  assign rsp.result_index  = head.idx;
  assign rsp.shifted_word  = head.word;
  assign rsp.set_bit_count = head.cnt;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= bsrm_pkg::PEND_W'(bsrm_pkg::FIFO_DEPTH))
    else $error("in-flight read count above queue depth");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    d_v |-> (fifo_cnt < (bsrm_pkg::FIFO_AW+1)'(bsrm_pkg::FIFO_DEPTH)))
    else $error("result queue written while full");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_take && (req.opcode == bsrm_pkg::OP_WRITE)) |=> !a_v)
    else $error("write item entered the read pipeline");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.set_bit_count == bsrm_pkg::CNT_W'($countones(rsp.shifted_word))))
    else $error("set-bit count does not match word");

  a_valid_pending: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (pending != '0))
    else $error("result shown with no read in flight");

endmodule

[sim/bitmap_shift_row_masked_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_shift_row_masked_top_tb: self-checking bench for the shifted bitmap
// Writes each source word before any read can reach it, then drives directed
// and random write/read items under several bitmap sizes and shifts. An
// in-bench bit-level model predicts every shifted word and its set-bit count;
// results are compared in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module bitmap_shift_row_masked_top_tb;

  localparam int    MEM_WORDS   = 65536;
  localparam longint PIXEL_CAP  = longint'(MEM_WORDS) * bsrm_pkg::WORD_BITS;
  localparam int    PIPE_SETTLE = 12;     // pad for the read pipeline
  localparam int    IDLE_LIMIT  = 4000;   // cycles with no item moving on either side
  localparam int    PHASES      = 12;
  localparam int    PHASE_ITEMS = 155;
  localparam int    PRINT_CAP   = 100;    // mismatch lines printed before going quiet

  typedef struct {
    logic [bsrm_pkg::IDX_W-1:0]     index;
    logic [bsrm_pkg::WORD_BITS-1:0] word;
    logic [bsrm_pkg::CNT_W-1:0]     count;
  } read_result_t;

  // Receiver stall patterns, picked at random by the receiver process.
  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_ONE_IN_FOUR,
    STALL_LONG
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [bsrm_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [bsrm_pkg::CFG_DATA_W-1:0] cfg_data;

  bsrm_req_if req ();
  bsrm_rsp_if rsp ();

  bitmap_shift_row_masked_top #(
    .MAX_WORDS(MEM_WORDS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .req      (req),
    .rsp      (rsp)
  );

  always #4 clk = ~clk;

  // Mirror of the block: source memory plus the four registers.
  logic [bsrm_pkg::WORD_BITS-1:0] src_words [0:MEM_WORDS-1];
  bit                             src_written [0:MEM_WORDS-1];
  int unsigned cfg_width;
  int unsigned cfg_rows;
  int          cfg_dx;
  int          cfg_dy;

  read_result_t pending_reads[$];   // shifted words still owed by the block
  int           err_count   = 0;
  int           burst_left  = 0;
  int           items_sent  = 0;
  int           quiet_cycles = 0;
  int           stall_tick  = 0;
  stall_mode_t  stall_mode  = STALL_NONE;

  // --------------------------------------------------------------------------
  // Shifted-word predictor: destination pixel p takes source pixel
  // p - dy*width - dx, blanked outside the bitmap and in the columns that a
  // horizontal shift of at most one row vacates.
  // --------------------------------------------------------------------------
  function automatic read_result_t predict_read(input logic [bsrm_pkg::IDX_W-1:0] idx);
    read_result_t r;
    longint n, words, w, dx, disp, lo, hi, p, s;
    bit masking, blank;
    n = longint'(cfg_width) * longint'(cfg_rows);
    if (n > PIXEL_CAP) n = PIXEL_CAP;
    words = (n + 31) >>> 5;
    w = cfg_width;
    dx = cfg_dx;
    disp = longint'(cfg_dy) * w + dx;
    masking = (w > 0) && (dx != 0) && (dx <= w) && (-dx <= w);
    lo = (dx < 0) ? w + dx : 0;
    hi = (dx < 0) ? w : dx;
    r.index = idx;
    r.word = '0;
    if (longint'(idx) < words) begin
      for (int k = 0; k < bsrm_pkg::WORD_BITS; k++) begin
        p = longint'(idx) * bsrm_pkg::WORD_BITS + k;
        s = p - disp;
        // pixels past the end, and sources outside the bitmap, stay clear
        blank = (p >= n) || (s < 0) || (s >= n);
        if (!blank && masking) blank = ((p % w) >= lo) && ((p % w) < hi);
        if (!blank) r.word[k] = src_words[s >>> 5][s[4:0]];
      end
    end
    r.count = $countones(r.word);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < PRINT_CAP)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t ns", what, got, want, $time);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Send one item. Open a new burst after a random gap when the current one
  // is spent; hold valid high across items within a burst.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [bsrm_pkg::OPCODE_W-1:0] op,
                           input logic [bsrm_pkg::IDX_W-1:0] idx,
                           input logic [bsrm_pkg::WORD_BITS-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // now and then a long stretch with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 32);
    end
    req.valid      <= 1'b1;
    req.opcode     <= op;
    req.word_index <= idx;
    req.word_value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    // advance the mirror in acceptance order
    if (op == bsrm_pkg::OP_READ) begin
      pending_reads.push_back(predict_read(idx));
    end else begin
      src_words[idx]   = val;
      src_written[idx] = 1'b1;
    end
  endtask

  // Drop valid, wait for every owed result, then let the pipe settle.
  task automatic wait_idle();
    req.valid <= 1'b0;
    burst_left = 0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic drive_reg(input logic [bsrm_pkg::CFG_ADDR_W-1:0] addr, input int value);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value[bsrm_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Reprogram all four registers once the block has gone idle.
  task automatic set_config(input int w, input int rows, input int dx, input int dy);
    wait_idle();
    drive_reg(bsrm_pkg::REG_ROW_WIDTH, w);
    drive_reg(bsrm_pkg::REG_ROW_COUNT, rows);
    drive_reg(bsrm_pkg::REG_SHIFT_X, dx);
    drive_reg(bsrm_pkg::REG_SHIFT_Y, dy);
    cfg_we <= 1'b0;
    cfg_width = w;
    cfg_rows  = rows;
    cfg_dx    = dx;
    cfg_dy    = dy;
  endtask

  function automatic int bitmap_words();
    longint n;
    n = longint'(cfg_width) * longint'(cfg_rows);
    if (n > PIXEL_CAP) n = PIXEL_CAP;
    return int'((n + 31) >>> 5);
  endfunction

  // Bias read indexes toward the first and last words and just past the end.
  function automatic logic [bsrm_pkg::IDX_W-1:0] pick_word_index(input int words);
    int last;
    if (words == 0 || $urandom_range(0, 7) == 0)
      return bsrm_pkg::IDX_W'($urandom_range(0, 65535));
    last = words - 1;
    case ($urandom_range(0, 3))
      0: return bsrm_pkg::IDX_W'($urandom_range(0, (last < 3) ? last : 3));
      1: return bsrm_pkg::IDX_W'(words - $urandom_range(0, (words < 4) ? words : 4));
      default: return bsrm_pkg::IDX_W'($urandom_range(0, last));
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 19))
      0:          return 0;
      1, 2:       return 1;
      3, 4:       return 4096;
      5, 6, 7, 8, 9, 10, 11, 12: return $urandom_range(1, 64);
      default:    return $urandom_range(65, 4096);
    endcase
  endfunction

  // Shifts around the span: inside it, exactly on it, one past it, extremes.
  function automatic int pick_shift(input int span);
    int v;
    int sign;
    if (span < 1) span = 1;
    if (span > 4095) span = 4095;
    sign = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 11))
      0:       v = 0;
      1, 2:    v = sign * span;
      3:       v = sign * (span + 1);
      4:       v = 4096;
      5:       v = -4096;
      6, 7, 8: v = sign * $urandom_range(1, (span < 8) ? span : 8);
      9:       v = sign * $urandom_range(1, span);
      default: v = int'($urandom_range(0, 8192)) - 4096;
    endcase
    return v;
  endfunction

  function automatic logic [bsrm_pkg::WORD_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Send a read, first writing any source word it can reach that holds no
  // data yet, so every read sees only written source words.
  task automatic send_read(input logic [bsrm_pkg::IDX_W-1:0] idx);
    longint n, s0;
    n = longint'(cfg_width) * longint'(cfg_rows);
    if (n > PIXEL_CAP) n = PIXEL_CAP;
    s0 = longint'(idx) * bsrm_pkg::WORD_BITS
         - (longint'(cfg_dy) * longint'(cfg_width) + longint'(cfg_dx));
    if (longint'(idx) * bsrm_pkg::WORD_BITS < n) begin
      for (longint wd = s0 >>> 5; wd <= ((s0 + 31) >>> 5); wd++) begin
        if (wd >= 0 && wd * bsrm_pkg::WORD_BITS < n && !src_written[wd])
          send_item(bsrm_pkg::OP_WRITE, bsrm_pkg::IDX_W'(wd), pick_value());
      end
    end
    send_item(bsrm_pkg::OP_READ, idx, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset geometry, 64 x 64 with no shift: identity copy of 128 words.
  task automatic test_reset_defaults();
    send_item(bsrm_pkg::OP_WRITE, 16'd5, '1);
    send_item(bsrm_pkg::OP_WRITE, 16'd6, '0);
    send_read(16'd0);
    send_read(16'd5);
    send_read(16'd6);
    send_read(16'd127);   // last bitmap word
    send_read(16'd128);   // first word past the end
    send_read(16'hFFFF);  // top of the index range
  endtask

  // Row mask: small right shift, full-row left shift, and one past the width.
  task automatic test_horizontal_shift();
    set_config(40, 8, 7, 0);
    send_read(16'd0);
    send_read(16'd9);
    set_config(40, 8, -40, 0);
    send_read(16'd3);
    set_config(40, 8, 41, 0);
    send_read(16'd2);
  endtask

  task automatic test_vertical_shift();
    set_config(64, 64, 0, -4096);
    send_read(16'd0);
    set_config(64, 64, -4096, 4096);
    send_read(16'd100);
    set_config(32, 16, 3, -2);
    send_read(16'd13);
    send_read(16'd15);
  endtask

  // Zero width or zero rows leave an empty bitmap.
  task automatic test_empty_bitmap();
    set_config(0, 64, 0, 0);
    send_read(16'd0);
    set_config(64, 0, 0, 0);
    send_read(16'd0);
  endtask

  // 4096 x 4096 pixels exceed the memory; the pixel count is capped.
  task automatic test_pixel_cap();
    set_config(4096, 4096, 1, 1);
    send_read(16'hFFFF);
    send_read(16'd0);
  endtask

  // 99 pixels: bits past the last pixel read as zero, also as shift sources.
  task automatic test_tail_pixels();
    set_config(33, 3, 0, -1);
    send_read(16'd3);
    send_read(16'd2);
  endtask

  // Random geometry per phase; within a phase, a read-heavy write/read mix.
  task automatic test_random_traffic();
    int w;
    int rows;
    int words;
    int phase_end;
    logic [bsrm_pkg::IDX_W-1:0] idx;
    for (int ph = 0; ph < PHASES; ph++) begin
      w = pick_dim();
      rows = pick_dim();
      // keep the shifts mostly in the interesting range for this geometry
      set_config(w, rows, pick_shift(w), ($urandom_range(0, 2) == 0) ?
                 pick_shift(rows) : int'($urandom_range(0, 6)) - 3);
      words = bitmap_words();
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        idx = pick_word_index(words);
        if ($urandom_range(0, 9) < 6) send_read(idx);
        else send_item(bsrm_pkg::OP_WRITE, idx, pick_value());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker and receiver stall pattern
  // --------------------------------------------------------------------------
  task automatic check_read_result();
    read_result_t want;
    if (pending_reads.size() == 0) begin
      report_mismatch("result with no read pending, index", rsp.result_index, 0);
    end else begin
      want = pending_reads.pop_front();
      if (rsp.result_index !== want.index)
        report_mismatch("result_index", rsp.result_index, want.index);
      if (rsp.shifted_word !== want.word)
        report_mismatch("shifted_word", rsp.shifted_word, want.word);
      if (rsp.set_bit_count !== want.count)
        report_mismatch("set_bit_count", rsp.set_bit_count, want.count);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) check_read_result();
      stall_tick++;
      if (stall_tick % 48 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:        rsp.ready <= 1'b1;
        STALL_COIN:        rsp.ready <= 1'($urandom_range(0, 1));
        STALL_ONE_IN_FOUR: rsp.ready <= (stall_tick % 4 == 0);
        default:           rsp.ready <= (stall_tick % 16 >= 12);
      endcase
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_addr       <= bsrm_pkg::REG_ROW_WIDTH;
    cfg_data       <= '0;
    req.valid      <= 1'b0;
    req.opcode     <= bsrm_pkg::OP_WRITE;
    req.word_index <= '0;
    req.word_value <= '0;
    cfg_width = bsrm_pkg::ROW_WIDTH_RST;
    cfg_rows  = bsrm_pkg::ROW_COUNT_RST;
    cfg_dx    = 0;
    cfg_dy    = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_horizontal_shift();
    test_vertical_shift();
    test_empty_bitmap();
    test_pixel_cap();
    test_tail_pixels();
    test_random_traffic();

    // drain: every owed result in, then the settle pad for stragglers
    wait_idle();
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
